@@ rtl/particle_push_linear_deposit_macros.svh @@
// Assertion macros shared by the particle push and deposit RTL.
`ifndef PARTICLE_PUSH_LINEAR_DEPOSIT_MACROS_SVH
`define PARTICLE_PUSH_LINEAR_DEPOSIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted (active low).
`define PPLD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define PPLD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPLD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PPLD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ rtl/ppld_pkg.sv @@
// Shared constants, types and helpers for the particle push and deposit block.
package ppld_pkg;

    localparam int MAX_NODES_DEF = 1024;

    localparam int POS_W      = 32;
    localparam int VEL_W      = 32;
    localparam int NODE_W     = 10;
    localparam int SUM_W      = 48;
    localparam int FRAC_W     = 22;
    localparam int CFG_W      = 32;
    localparam int REG_IDX_W  = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 88;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Item kinds carried in s_axis_tuser
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_CELL_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP_SCALE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_INV_CELL   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_MUL,
        ST_P_DISP,
        ST_P_ADD,
        ST_P_WRAP,
        ST_P_CLAMP,
        ST_P_WMUL,
        ST_D_RD0,
        ST_D_WR0,
        ST_D_WR1,
        ST_R_CHK,
        ST_R_HI,
        ST_R_LO,
        ST_R_SAT,
        ST_RES
    } state_t;

    // Saturating add of two node sums.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

@@ rtl/ppld_node_store.sv @@
// Node sum memory with registered read and a zeroing sweep after reset.
`include "particle_push_linear_deposit_macros.svh"

module ppld_node_store
    import ppld_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int AW = $clog2(MAX_NODES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [SUM_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [SUM_W-1:0] rd_data,
    output logic             busy
);

    logic [SUM_W-1:0] sums_mem [MAX_NODES];
    logic [AW-1:0]    clr_cnt_reg;
    logic             busy_reg;
    logic [SUM_W-1:0] rd_data_reg;

    // Sweep every entry to zero once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end else if (busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_NODES - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            sums_mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            sums_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= sums_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

    `PPLD_ASSERT_IMP(a_no_wr_in_sweep, aclk, aresetn, busy_reg, !wr_en, "write during sweep")
    `PPLD_ASSERT_IMP(a_no_rd_in_sweep, aclk, aresetn, busy_reg, !rd_en, "read during sweep")
    `PPLD_ASSERT_IMP(a_no_same_entry, aclk, aresetn, rd_en && wr_en, rd_addr != wr_addr,
                     "read and write hit the same entry")

endmodule

@@ rtl/particle_push_linear_deposit.sv @@
// Top level of the 1-D particle push with linear (cloud-in-cell) deposition.
//
// Usage:
//   s_axis_* carries one item per handshake. s_axis_tuser selects push (0) or
//   node readout (1). A push item moves the particle, wraps it once over the
//   periodic domain, clamps and flags an overrun, returns the new position and
//   adds the weight to the two nodes around it. A readout item returns the
//   node sum times the inverse cell size (doubled at the end nodes) and
//   clears the node.
//   m_axis_* returns exactly one result item per input item, in order.
//   cfg_* writes one configuration register per cycle with cfg_wr_en high;
//   write only while no item is in flight.
// Sequence:
//   Push steps through multiply, round, add, wrap, clamp, split and two
//   read-modify-write passes over the single node memory. Readout steps
//   through the memory read and two 48x16 partial products, which an
//   out-of-range node skips. One item is in the sequencer at a time.
// Reset: configuration returns to its defaults and the node memory is swept
//   to zero, one entry a cycle; s_axis_tready stays low meanwhile.
// Stall: a finished result waits in the output register while the next item
//   is accepted; the sequencer holds at the end until the register is free.
`include "particle_push_linear_deposit_macros.svh"

module particle_push_linear_deposit
    import ppld_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // position[31:0], velocity[63:32], node_index[73:64], zero pad[79:74]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_position[31:0], density[79:32], overrun[80], bad_index[81], zero pad[87:82]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    // node numbers wide enough to hold MAX_NODES itself
    localparam int NW = (AW > NODE_W) ? AW + 1 : NODE_W + 2;

    // configuration
    logic [NODE_W-1:0] cell_count_reg;
    logic [CFG_W-1:0]  step_scale_reg;
    logic [CFG_W-1:0]  weight_reg;
    logic [CFG_W-1:0]  inv_cell_reg;

    // sequencer
    state_t state_reg, state_next;

    // item and working registers
    logic              kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic [NODE_W-1:0] node_reg;
    logic [63:0]       prod_reg;
    logic [37:0]       dmag_reg;
    logic signed [39:0] p_reg;
    logic signed [39:0] w_reg;
    logic [POS_W-1:0]  posf_reg;
    logic              over_reg;
    logic [CFG_W-1:0]  right_reg;
    logic [CFG_W-1:0]  left_reg;
    logic [63:0]       hi_reg;
    logic [SUM_W-1:0]  lo_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  dens_reg;
    logic              bad_reg;

    // output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // memory port
    logic             mem_we, mem_re, mem_busy;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [SUM_W-1:0] mem_wdata, mem_rdata;

    logic s_ready;
    logic out_load;
    logic in_accept;

    // datapath nets
    logic [NODE_W-1:0]  cells;
    logic [POS_W-1:0]   len;
    logic signed [39:0] len_s;
    logic               neg;
    logic [VEL_W-1:0]   mag;
    logic [63:0]        rnd;
    logic signed [39:0] pos_ext, d_ext, p_sum, w_next;
    logic [POS_W-1:0]   posf_next;
    logic               over_next;
    logic [53:0]        wprod;
    logic [NW-1:0]      node0, node1, nidx, max_n;
    logic               node0_ok, node1_ok, bad_chk;
    logic [63:0]        hi_prod, lo_prod;
    logic [SUM_W-1:0]   sat_dens, dbl_dens, rmw_data;
    logic [CFG_W-1:0]   add_in;

    ppld_node_store #(
        .MAX_NODES(MAX_NODES)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata),
        .busy    (mem_busy)
    );

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg <= NODE_W'(1023);
            step_scale_reg <= '0;
            weight_reg     <= CFG_W'(65536);
            inv_cell_reg   <= CFG_W'(65536);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CELL_COUNT: cell_count_reg <= cfg_data[NODE_W-1:0];
                REG_STEP_SCALE: step_scale_reg <= cfg_data;
                REG_WEIGHT:     weight_reg     <= cfg_data;
                REG_INV_CELL:   inv_cell_reg   <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath arithmetic
    // ------------------------------------------------------------------
    // a zero cell count acts as one cell
    assign cells = (cell_count_reg == '0) ? NODE_W'(1) : cell_count_reg;
    assign len   = {cells, {FRAC_W{1'b0}}};
    assign len_s = $signed({8'b0, len});

    assign neg = vel_reg[VEL_W-1];
    assign mag = neg ? (~vel_reg + VEL_W'(1)) : vel_reg;

    // drop 26 bits, rounding toward minus infinity for negative motion
    assign rnd = neg ? (prod_reg + 64'h3FF_FFFF) : prod_reg;

    assign pos_ext = $signed({8'b0, pos_reg});
    assign d_ext   = $signed({2'b0, dmag_reg});
    assign p_sum   = neg ? (pos_ext - d_ext) : (pos_ext + d_ext);

    // one periodic wrap
    always_comb begin
        if (p_reg < 40'sd0) begin
            w_next = p_reg + len_s;
        end else if (p_reg >= len_s) begin
            w_next = p_reg - len_s;
        end else begin
            w_next = p_reg;
        end
    end

    // clamp whatever one wrap could not bring inside
    always_comb begin
        over_next = 1'b0;
        if (w_reg < 40'sd0) begin
            posf_next = '0;
            over_next = 1'b1;
        end else if (w_reg >= len_s) begin
            posf_next = len - POS_W'(1);
            over_next = 1'b1;
        end else begin
            posf_next = w_reg[POS_W-1:0];
        end
    end

    assign wprod = weight_reg * posf_reg[FRAC_W-1:0];

    assign node0    = {{(NW-NODE_W){1'b0}}, posf_reg[POS_W-1:FRAC_W]};
    assign node1    = node0 + NW'(1);
    assign max_n    = NW'(MAX_NODES);
    assign node0_ok = node0 < max_n;
    assign node1_ok = node1 < max_n;

    assign nidx    = {{(NW-NODE_W){1'b0}}, node_reg};
    assign bad_chk = (node_reg > cells) || (nidx >= max_n);

    assign hi_prod = mem_rdata * inv_cell_reg[31:16];
    assign lo_prod = sum_reg * inv_cell_reg[15:0];

    assign sat_dens = (hi_reg[63:SUM_W] != '0) ? SUM_MAX : sat_add(hi_reg[SUM_W-1:0], lo_reg);
    // end nodes see only half a cell
    assign dbl_dens = ((node_reg == '0) || (node_reg == cells)) ?
                      sat_add(dens_reg, dens_reg) : dens_reg;

    assign add_in   = (state_reg == ST_D_WR0) ? left_reg : right_reg;
    assign rmw_data = sat_add(mem_rdata, {{(SUM_W-CFG_W){1'b0}}, add_in});

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign in_accept = s_axis_tvalid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_axis_tuser[0] == KIND_READ) ? ST_R_CHK : ST_P_MUL;
                end
            end
            ST_P_MUL:   state_next = ST_P_DISP;
            ST_P_DISP:  state_next = ST_P_ADD;
            ST_P_ADD:   state_next = ST_P_WRAP;
            ST_P_WRAP:  state_next = ST_P_CLAMP;
            ST_P_CLAMP: state_next = ST_P_WMUL;
            ST_P_WMUL:  state_next = ST_D_RD0;
            ST_D_RD0:   state_next = ST_D_WR0;
            ST_D_WR0:   state_next = ST_D_WR1;
            ST_D_WR1:   state_next = ST_RES;
            ST_R_CHK:   state_next = bad_chk ? ST_RES : ST_R_HI;
            ST_R_HI:    state_next = ST_R_LO;
            ST_R_LO:    state_next = ST_R_SAT;
            ST_R_SAT:   state_next = ST_RES;
            ST_RES: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (memory port, ready, result load)
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = node0[AW-1:0];
        mem_raddr = node0[AW-1:0];
        mem_wdata = rmw_data;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !mem_busy;
            end
            ST_D_RD0: begin
                mem_re = 1'b1;
            end
            ST_D_WR0: begin
                // write the left node, fetch the right one
                mem_we    = node0_ok;
                mem_re    = node1_ok;
                mem_raddr = node1[AW-1:0];
            end
            ST_D_WR1: begin
                mem_we    = node1_ok;
                mem_waddr = node1[AW-1:0];
            end
            ST_R_CHK: begin
                mem_re    = !bad_chk;
                mem_raddr = nidx[AW-1:0];
            end
            ST_R_HI: begin
                // clear the node once its sum is in hand
                mem_we    = 1'b1;
                mem_waddr = nidx[AW-1:0];
                mem_wdata = '0;
            end
            ST_RES: begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Working registers (payload, no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    kind_reg <= s_axis_tuser[0];
                    pos_reg  <= s_axis_tdata[POS_W-1:0];
                    vel_reg  <= s_axis_tdata[POS_W+VEL_W-1:POS_W];
                    node_reg <= s_axis_tdata[POS_W+VEL_W+NODE_W-1:POS_W+VEL_W];
                end
            end
            ST_P_MUL:   prod_reg <= mag * step_scale_reg;
            ST_P_DISP:  dmag_reg <= rnd[63:26];
            ST_P_ADD:   p_reg    <= p_sum;
            ST_P_WRAP:  w_reg    <= w_next;
            ST_P_CLAMP: begin
                posf_reg <= posf_next;
                over_reg <= over_next;
            end
            ST_P_WMUL:  right_reg <= wprod[53:FRAC_W];
            ST_D_RD0:   left_reg  <= weight_reg - right_reg;
            ST_R_CHK: begin
                bad_reg  <= bad_chk;
                dens_reg <= '0;
            end
            ST_R_HI: begin
                sum_reg <= mem_rdata;
                hi_reg  <= hi_prod;
            end
            ST_R_LO:    lo_reg   <= lo_prod[63:16];
            ST_R_SAT:   dens_reg <= sat_dens;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: hold until taken, refill in the same cycle
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (kind_reg == KIND_PUSH) begin
                out_data_reg <= {6'b0, 1'b0, over_reg, {SUM_W{1'b0}}, posf_reg};
            end else begin
                out_data_reg <= {6'b0, bad_reg, 1'b0, dbl_dens, {POS_W{1'b0}}};
            end
        end
    end

    assign s_axis_tready = s_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `PPLD_ASSERT_IMP(a_hold_in_sweep, aclk, aresetn, mem_busy, !s_axis_tready,
                     "item accepted during memory sweep")
    `PPLD_ASSERT_NXT(a_leave_idle, aclk, aresetn, in_accept, state_reg != ST_IDLE,
                     "sequencer did not start on accepted item")
    `PPLD_ASSERT_IMP(a_bad_zero, aclk, aresetn, m_axis_tvalid && m_axis_tdata[81],
                     m_axis_tdata[79:32] == '0, "bad readout with nonzero density")

endmodule

@@ dv/ppld_checker.sv @@
// Checker for the particle push and deposit block: predicts each result and compares it.
module ppld_checker
    import ppld_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [POS_W-1:0] new_position;
        logic [SUM_W-1:0] density;
        logic             overrun;
        logic             bad_index;
    } push_result_t;

    logic [NODE_W-1:0] cell_count;
    logic [CFG_W-1:0]  step_scale;
    logic [CFG_W-1:0]  weight;
    logic [CFG_W-1:0]  inv_cell;
    logic [SUM_W-1:0]  node_sum [MAX_NODES];
    push_result_t      result_q [$];
    push_result_t      want;
    push_result_t      got;

    function automatic logic [SUM_W-1:0] clip_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic int domain_cells();
        return (cell_count == 0) ? 1 : int'(cell_count);
    endfunction

    function automatic void add_charge(input longint node, input logic [63:0] amount);
        if (node < MAX_NODES)
            node_sum[node] = clip_add(node_sum[node], amount[SUM_W-1:0]);
    endfunction

    // Move one particle, wrap and clamp it, then spread its weight over two nodes.
    function automatic push_result_t push_particle(input logic [POS_W-1:0] pos,
                                                   input logic [VEL_W-1:0] vel);
        push_result_t  r;
        logic [31:0]   mag;
        logic [63:0]   prod;
        longint        disp;
        longint        p;
        longint        span;
        logic [63:0]   up;
        logic [63:0]   right;
        logic [21:0]   frac;
        r = '0;
        span = longint'(domain_cells()) << FRAC_W;
        mag = vel[31] ? (~vel + 32'd1) : vel;
        prod = {32'd0, mag} * {32'd0, step_scale};
        // Floor toward minus infinity: round the magnitude up on negative steps.
        if (vel[31])
            disp = -longint'((prod + 64'h3FF_FFFF) >> 26);
        else
            disp = longint'(prod >> 26);
        p = longint'({32'd0, pos}) + disp;
        if (p < 0)
            p = p + span;
        else if (p >= span)
            p = p - span;
        if (p < 0) begin
            p = 0;
            r.overrun = 1'b1;
        end else if (p >= span) begin
            p = span - 1;
            r.overrun = 1'b1;
        end
        up = p;
        frac = up[FRAC_W-1:0];
        right = ({32'd0, weight} * {42'd0, frac}) >> FRAC_W;
        add_charge(longint'(up >> FRAC_W), {32'd0, weight} - right);
        add_charge(longint'(up >> FRAC_W) + 1, right);
        r.new_position = up[POS_W-1:0];
        return r;
    endfunction

    // Scale one node sum by the inverse cell size and clear the node.
    function automatic push_result_t read_node(input logic [NODE_W-1:0] node);
        push_result_t r;
        int           n;
        int           cells;
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [SUM_W-1:0] dens;
        r = '0;
        n = int'(node);
        cells = domain_cells();
        if (n > cells || n >= MAX_NODES) begin
            r.bad_index = 1'b1;
        end else begin
            hi = {16'd0, node_sum[n]} * {48'd0, inv_cell[31:16]};
            lo = ({16'd0, node_sum[n]} * {48'd0, inv_cell[15:0]}) >> 16;
            if (hi > {16'd0, {SUM_W{1'b1}}})
                dens = {SUM_W{1'b1}};
            else
                dens = clip_add(hi[SUM_W-1:0], lo[SUM_W-1:0]);
            // End nodes see only half a cell.
            if (n == 0 || n == cells)
                dens = clip_add(dens, dens);
            r.density = dens;
            node_sum[n] = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cell_count = 10'd1023;
            step_scale = '0;
            weight     = 32'd65536;
            inv_cell   = 32'd65536;
            for (int k = 0; k < MAX_NODES; k++)
                node_sum[k] = '0;
            result_q.delete();
            errors = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CELL_COUNT: cell_count = cfg_data[NODE_W-1:0];
                    REG_STEP_SCALE: step_scale = cfg_data;
                    REG_WEIGHT:     weight     = cfg_data;
                    REG_INV_CELL:   inv_cell   = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == KIND_PUSH)
                    result_q = {result_q,
                                push_particle(s_axis_tdata[31:0], s_axis_tdata[63:32])};
                else
                    result_q = {result_q, read_node(s_axis_tdata[73:64])};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.new_position = m_axis_tdata[31:0];
                got.density      = m_axis_tdata[79:32];
                got.overrun      = m_axis_tdata[80];
                got.bad_index    = m_axis_tdata[81];
                if (result_q.size() == 0) begin
                    $display("%0t ns: result with none outstanding, expected nothing, got %0h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    check_field("new_position", 64'(want.new_position),
                                64'(got.new_position));
                    check_field("density", 64'(want.density), 64'(got.density));
                    check_field("overrun", 64'(want.overrun), 64'(got.overrun));
                    check_field("bad_index", 64'(want.bad_index), 64'(got.bad_index));
                end
            end
        end
        pending <= result_q.size();
    end

endmodule

@@ dv/tb_particle_push_linear_deposit.sv @@
// Testbench top for the particle push and deposit block: stimulus, flow control and verdict.
module tb_particle_push_linear_deposit
    import ppld_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int DRAIN_CYCLES  = 12;   // extra wait after the last result, as margin

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // position[31:0], velocity[63:32], node_index[73:64], zero pad[79:74]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // kind[0]
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // new_position[31:0], density[79:32], overrun[80], bad_index[81], zero pad[87:82]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    int errors;
    int pending;
    int tx_mode = 0;          // sender gap profile: 0 none, 1 light, 2 heavy
    int rx_mode = 0;          // receiver stall profile, same scale
    int rx_hold = 0;
    int cur_cells = 1023;     // our copy of cell_count, used to aim positions and nodes

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    particle_push_linear_deposit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ppld_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    // Often no gap, else mostly short gaps, now and then a long one; profile 0 gives none at all.
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (r < ((mode == 1) ? 20 : 45))
            return $urandom_range(1, 3);
        if (r < ((mode == 1) ? 23 : 55))
            return $urandom_range(8, 30);
        return 0;
    endfunction

    // Receiver back-pressure: hold tready low for a random stretch, then release.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rx_hold <= pick_gap(rx_mode);
            m_axis_tready <= 1'b1;
        end
    end

    // Present one item and hold it until accepted; valid stays high for back-to-back items.
    task automatic send_item(input logic kind, input logic [31:0] pos,
                             input logic [31:0] vel, input logic [9:0] node);
        int gap;
        gap = pick_gap(tx_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, node, vel, pos};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] cells, input logic [CFG_W-1:0] step,
                              input logic [CFG_W-1:0] wgt, input logic [CFG_W-1:0] inv);
        write_reg(REG_CELL_COUNT, cells);
        write_reg(REG_STEP_SCALE, step);
        write_reg(REG_WEIGHT, wgt);
        write_reg(REG_INV_CELL, inv);
        cfg_wr_en <= 1'b0;
        cur_cells = int'(cells[NODE_W-1:0]);
        @(posedge aclk);
    endtask

    // Random register value with the extremes and the unit value well represented.
    function automatic logic [CFG_W-1:0] pick_reg(input logic [REG_IDX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 99);
        if (idx == REG_CELL_COUNT) begin
            if (r < 12) return 0;
            if (r < 25) return 1;
            if (r < 40) return 1023;
            if (r < 60) return $urandom_range(2, 6);
            return $urandom_range(1, 1023);
        end
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 40)
            return (idx == REG_STEP_SCALE) ? (32'd1 << $urandom_range(20, 31)) : 32'd65536;
        return $urandom;
    endfunction

    // Mostly pushes inside the domain with moderate speed, plus full-range noise.
    task automatic run_random(input int count);
        int          dom;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [9:0]  node;
        dom = (cur_cells == 0) ? 1 : cur_cells;
        for (int i = 0; i < count; i++) begin
            pos  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, (dom << FRAC_W) - 1)
                                               : $urandom;
            vel  = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 32'h20_0000) - 32'h10_0000
                                              : $urandom;
            node = 10'(($urandom_range(0, 3) != 0) ? $urandom_range(0, dom) : $urandom);
            if ($urandom_range(0, 99) < 70)
                send_item(KIND_PUSH, pos, vel, node);
            else
                send_item(KIND_READ, pos, vel, node);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: full domain, no motion, unit weight and scale.
        send_item(KIND_PUSH, 32'h0000_0000, 32'h0000_0000, 10'd0);
        send_item(KIND_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 10'd1023);   // wraps back inside
        send_item(KIND_PUSH, 32'hFFBF_FFFF, 32'h8000_0000, 10'd0);      // last cell
        send_item(KIND_READ, 32'h0, 32'h0, 10'd0);
        send_item(KIND_READ, 32'h0, 32'h0, 10'd1);
        send_item(KIND_READ, 32'h0, 32'h0, 10'd1022);
        send_item(KIND_READ, 32'h0, 32'h0, 10'd1023);                   // end node, doubled
        send_item(KIND_READ, 32'h0, 32'h0, 10'd1023);                   // cleared by last read
        wait_idle();

        // Zero cell count acts as one cell; everything else at its maximum.
        set_config(32'd0, '1, '1, '1);
        send_item(KIND_PUSH, 32'h0000_0000, 32'h7FFF_FFFF, 10'd0);      // overrun high
        send_item(KIND_PUSH, 32'h0000_0000, 32'h8000_0000, 10'd0);      // overrun low
        send_item(KIND_PUSH, 32'hFFFF_FFFF, 32'h0000_0000, 10'd0);      // one wrap not enough
        send_item(KIND_PUSH, 32'h0020_0000, 32'h0000_0000, 10'd0);      // half-cell split
        send_item(KIND_READ, 32'h0, 32'h0, 10'd0);                      // saturates
        send_item(KIND_READ, 32'h0, 32'h0, 10'd1);                      // far end node
        send_item(KIND_READ, 32'h0, 32'h0, 10'd2);                      // beyond cell count
        send_item(KIND_READ, 32'h0, 32'h0, 10'd1023);
        wait_idle();

        // Zero weight and zero inverse cell size, with a small step.
        set_config(32'd1023, 32'h0400_0000, '0, '0);
        send_item(KIND_PUSH, 32'h0000_0000, 32'hFFFF_FFFF, 10'd0);      // wraps to the top
        send_item(KIND_READ, 32'h0, 32'h0, 10'd1022);
        send_item(KIND_READ, 32'h0, 32'h0, 10'd0);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tx_mode = ph % 3;
            rx_mode = (ph / 3 + ph) % 3;
            set_config(pick_reg(REG_CELL_COUNT), pick_reg(REG_STEP_SCALE),
                       pick_reg(REG_WEIGHT), pick_reg(REG_INV_CELL));
            run_random(PHASE_ITEMS);
            wait_idle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
